@@ src/lpht_pkg.sv @@
// Shared types and constants for the linear-probing hash table.
// Holds request/response payload structs, controller/datapath command and status
// structs, action and status codes. No dependencies.
package lpht_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;

    // The key modulo is worked out two quotient bits per cycle.
    localparam int DIV_BITS    = 2;
    localparam int DIV_STEPS   = KEY_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef logic [1:0] action_t;
    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_SEARCH = 2'd1;
    localparam action_t ACT_DELETE = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_MISSING = 2'd1;
    localparam status_t ST_FULL    = 2'd2;

    typedef struct packed {
        action_t            action;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } lpht_req_t;

    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   found_value;
        logic [IDX_W-1:0]   slot_index;
        logic [CNT_W-1:0]   entry_count;
    } lpht_rsp_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic probe_start;
        logic probe_step;
        logic commit;
    } lpht_cmd_t;

    typedef struct packed {
        logic div_last;
        logic probe_end;
        logic out_free;
    } lpht_stat_t;

endpackage

@@ src/lpht_ctrl.sv @@
// Sequencing state machine for the hash table: accept, key modulo, probe walk.
// Drives commands into lpht_dp and reads its status; uses lpht_pkg.
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  lpht_stat_t stat,
    output lpht_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_START = 4'b0100,
        S_PROBE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.probe_start = 1'b1;
                state_next      = S_PROBE;
            end
            S_PROBE:
            begin
                // Hold the finished probe until the response register can take it.
                if (stat.probe_end)
                begin
                    if (stat.out_free)
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.probe_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

@@ src/lpht_dp.sv @@
// Datapath of the hash table: size register, key modulo unit, slot stores,
// probe pipeline and response register. Commanded by lpht_ctrl; uses lpht_pkg.
module lpht_dp
    import lpht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lpht_req_t        req,
    input  logic             cfg_valid,
    input  logic [CNT_W-1:0] cfg_table_size,
    input  lpht_cmd_t        cmd,
    output lpht_stat_t       stat,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output lpht_rsp_t        rsp
);

    // One restoring step of the modulo: shift in a dividend bit, subtract if possible.
    function automatic logic [IDX_W-1:0] mod_step(
        input logic [IDX_W-1:0] rem,
        input logic             bit_in,
        input logic [CNT_W-1:0] n
    );
        logic [CNT_W-1:0] t;
        t = {rem, bit_in};
        if (t >= n)
        begin
            t = t - n;
        end
        return t[IDX_W-1:0];
    endfunction

    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        n_eff;

    action_t                 act_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [VAL_W-1:0]        val_reg;

    logic [KEY_W-1:0]        div_reg;
    logic [IDX_W-1:0]        rem_reg;
    logic [IDX_W-1:0]        rem_next;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;

    logic [CNT_W-1:0]        rd_idx_reg;
    logic                    chk_vld_reg;
    logic                    chk_used_reg;
    logic [IDX_W-1:0]        chk_idx_reg;
    logic [KEY_W-1:0]        key_q_reg;
    logic [VAL_W-1:0]        val_q_reg;

    logic [TABLE_DEPTH-1:0]  used_reg;
    logic [KEY_W-1:0]        key_mem [TABLE_DEPTH];
    logic [VAL_W-1:0]        val_mem [TABLE_DEPTH];

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    logic                    rsp_vld_reg;
    lpht_rsp_t               rsp_reg;

    logic                    is_ins;
    logic                    is_find;
    logic                    hit;
    logic                    rd_ok;
    logic                    wr_en;

    // A size of zero acts as one, and anything beyond the table acts as the full table.
    always_comb
    begin
        n_eff = cfg_table_size;
        if (cfg_table_size == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (cfg_table_size > CNT_W'(TABLE_DEPTH))
        begin
            n_eff = CNT_W'(TABLE_DEPTH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= CNT_W'(TABLE_DEPTH);
        end
        else if (cfg_valid)
        begin
            n_reg <= n_eff;
        end
    end

    // Request capture and key modulo.
    always_comb
    begin
        rem_next = mod_step(rem_reg, div_reg[KEY_W-1], n_reg);
        rem_next = mod_step(rem_next, div_reg[KEY_W-2], n_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= req.action;
            key_reg <= req.key;
            val_reg <= req.value;
            div_reg <= req.key;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_reg <= div_reg << DIV_BITS;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    assign stat.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // Probe walk: one slot read per cycle, checked in the cycle after.
    assign rd_ok = (rd_idx_reg < n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg  <= '0;
            chk_vld_reg <= 1'b0;
        end
        else if (cmd.probe_start)
        begin
            rd_idx_reg  <= {1'b0, rem_reg};
            chk_vld_reg <= 1'b0;
        end
        else if (cmd.probe_step)
        begin
            if (rd_ok)
            begin
                rd_idx_reg  <= rd_idx_reg + CNT_W'(1);
                chk_vld_reg <= 1'b1;
            end
            else
            begin
                chk_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe_step && rd_ok)
        begin
            chk_idx_reg  <= rd_idx_reg[IDX_W-1:0];
            chk_used_reg <= used_reg[rd_idx_reg[IDX_W-1:0]];
        end
    end

    assign is_ins  = (act_reg == ACT_INSERT);
    assign is_find = (act_reg == ACT_SEARCH) || (act_reg == ACT_DELETE);
    assign hit     = chk_vld_reg
                     && ((is_ins && !chk_used_reg)
                         || (is_find && chk_used_reg && (key_q_reg == key_reg)));

    assign stat.probe_end = chk_vld_reg && (hit || (rd_idx_reg == n_reg));

    // Slot stores: key and value memories, occupancy flags in flip-flops.
    assign wr_en = cmd.commit && hit && is_ins;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[chk_idx_reg] <= key_reg;
            val_mem[chk_idx_reg] <= val_reg;
        end
        if (cmd.probe_step && rd_ok)
        begin
            key_q_reg <= key_mem[rd_idx_reg[IDX_W-1:0]];
            val_q_reg <= val_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (hit && is_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (hit && (act_reg == ACT_DELETE) && (count_reg != '0))
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
            if (hit && is_ins)
            begin
                used_reg[chk_idx_reg] <= 1'b1;
            end
            else if (hit && (act_reg == ACT_DELETE))
            begin
                used_reg[chk_idx_reg] <= 1'b0;
            end
        end
    end

    // Response register: a finished result waits here while the next request is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            rsp_vld_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.entry_count <= count_next;
            if (hit)
            begin
                rsp_reg.status      <= ST_OK;
                rsp_reg.slot_index  <= chk_idx_reg;
                rsp_reg.found_value <= is_find ? val_q_reg : '0;
            end
            else
            begin
                rsp_reg.status      <= is_ins ? ST_FULL : ST_MISSING;
                rsp_reg.slot_index  <= '0;
                rsp_reg.found_value <= '0;
            end
        end
    end

    assign stat.out_free = !rsp_vld_reg || !rsp_stall;
    assign rsp_valid     = rsp_vld_reg;
    assign rsp           = rsp_reg;

endmodule

@@ src/linear_probing_hash_table.sv @@
// Linear-probing key/value table. A request is taken, its home slot found by a modulo
// unit that resolves two key bits per cycle, then slots are probed one read per cycle;
// the result is registered when the probe ends and the response register is free,
// and the next request can be taken in the cycle after that.
// Reset clears the occupancy flags and entry count at once and sets the size to 64;
// there is no clearing pass. Uses lpht_pkg, lpht_ctrl and lpht_dp.
module linear_probing_hash_table
    import lpht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  lpht_req_t        req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output lpht_rsp_t        rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_table_size
);

    lpht_cmd_t  cmd;
    lpht_stat_t stat;

    assign cfg_ready = 1'b1;

    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lpht_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_table_size (cfg_table_size),
        .cmd            (cmd),
        .stat           (stat),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp)
    );

endmodule
